/* src/htebp_pkg.sv */
// shared types and constants for the huffman table encoder and bit packer
package htebp_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_CODE_LEN = 32;
    localparam int VALUE_W      = 32;
    localparam int LEN_W        = 6;
    localparam int CODE_LIMIT   = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [BYTE_W-1:0] EOF_RESET = 8'd129;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_END    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        REG_EOF_SYMBOL = 1'b0,
        REG_UNUSED     = 1'b1
    } reg_index_t;

    typedef enum logic {
        PK_IDLE = 1'b0,
        PK_RUN  = 1'b1
    } pk_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   length;
    } entry_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   length;
        logic               is_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* src/htebp_if.sv */
// word channels: input items and packed output bytes
interface htebp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;
    logic [31:0] code_value;
    logic [5:0] code_length;

    modport source (output valid, action, symbol, code_value, code_length, input ready);
    modport sink (input valid, action, symbol, code_value, code_length, output ready);
endinterface

interface htebp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, out_byte, last_of_run, stream_end, input ready);
    modport sink (input valid, out_byte, last_of_run, stream_end, output ready);
endinterface

/* src/htebp_front.sv */
// front end: code table memory, table lookup and command issue
module htebp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    htebp_in_if.sink                          in_ch,
    input  logic [htebp_pkg::BYTE_W-1:0]      eof_symbol,
    input  htebp_pkg::q_status_t              q_status,
    output logic                              push,
    output htebp_pkg::cmd_t                   push_cmd
);

    htebp_pkg::entry_t mem [htebp_pkg::TABLE_DEPTH];
    htebp_pkg::entry_t rd_data_reg;
    htebp_pkg::entry_t wr_entry;
    htebp_pkg::action_t act;

    logic s2_valid_reg, s2_valid_next;
    logic s2_end_reg, s2_end_next;
    logic accept;
    logic do_write, do_read;
    logic [htebp_pkg::ADDR_W-1:0] rd_addr;

    assign act          = htebp_pkg::action_t'(in_ch.action);
    assign in_ch.ready  = !s2_valid_reg || !q_status.full;
    assign accept       = in_ch.valid && in_ch.ready;
    assign push         = s2_valid_reg && !q_status.full;
    assign push_cmd     = '{value: rd_data_reg.value, length: rd_data_reg.length,
                            is_end: s2_end_reg};

    always_comb
    begin
        do_write = 1'b0;
        do_read  = 1'b0;
        rd_addr  = in_ch.symbol[htebp_pkg::ADDR_W-1:0];
        unique case (act)
            htebp_pkg::ACT_LOAD:   do_write = accept;
            htebp_pkg::ACT_ENCODE: do_read  = accept;
            htebp_pkg::ACT_END:
            begin
                do_read = accept;
                rd_addr = eof_symbol[htebp_pkg::ADDR_W-1:0];
            end
            htebp_pkg::ACT_NONE:   do_read  = 1'b0;
        endcase
    end

    // lengths beyond the supported code width saturate
    always_comb
    begin
        wr_entry.value  = in_ch.code_value;
        wr_entry.length = (in_ch.code_length > htebp_pkg::LEN_W'(htebp_pkg::CODE_LIMIT))
                        ? htebp_pkg::LEN_W'(htebp_pkg::CODE_LIMIT) : in_ch.code_length;
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[in_ch.symbol[htebp_pkg::ADDR_W-1:0]] <= wr_entry;
        end
        if (do_read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_end_next   = s2_end_reg;
        if (accept)
        begin
            s2_valid_next = do_read;
            s2_end_next   = (act == htebp_pkg::ACT_END);
        end
        else if (push)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_end_reg   <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s2_end_reg   <= s2_end_next;
        end
    end

endmodule

/* src/htebp_cmd_fifo.sv */
// short command queue between lookup and packer
module htebp_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  htebp_pkg::cmd_t      push_cmd,
    input  logic                 pop,
    output htebp_pkg::cmd_t      head,
    output htebp_pkg::q_status_t status
);

    htebp_pkg::cmd_t slot_reg [htebp_pkg::QUEUE_DEPTH];
    logic [htebp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [htebp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [htebp_pkg::QPTR_W:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign status.full  = (count_reg == (htebp_pkg::QPTR_W+1)'(htebp_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/htebp_packer.sv */
// back end: msb-first bit packer, at most one byte per cycle unless out_ch stalls
module htebp_packer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  htebp_pkg::cmd_t      head,
    input  htebp_pkg::q_status_t q_status,
    output logic                 pop,
    htebp_out_if.source          out_ch
);

    localparam int FILL_W = htebp_pkg::CNT_W + 1;

    htebp_pkg::pk_state_t state_reg, state_next;

    logic [htebp_pkg::BYTE_W-1:0]  buf_reg, buf_next;
    logic [htebp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [htebp_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [htebp_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic                          end_reg, end_next;

    logic                          out_valid_reg, out_valid_next;
    logic [htebp_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_end_reg, out_end_next;

    logic                          out_free;
    logic [FILL_W-1:0]             space, take, fill;
    logic [htebp_pkg::BYTE_W-1:0]  top_bits, merged;
    logic [htebp_pkg::LEN_W-1:0]   rem_after;
    logic                          zero_rem, full, done;
    logic                          emit, emit_last, emit_end;
    logic [htebp_pkg::BYTE_W-1:0]  emit_byte;

    assign out_free = !out_valid_reg || out_ch.ready;

    // bits taken this cycle: whatever fits in the partial byte
    always_comb
    begin
        space     = FILL_W'(htebp_pkg::BYTE_W) - {1'b0, cnt_reg};
        take      = (rem_reg < htebp_pkg::LEN_W'(space)) ? rem_reg[FILL_W-1:0] : space;
        top_bits  = val_reg[htebp_pkg::VALUE_W-1 -: htebp_pkg::BYTE_W]
                  & ~(8'hFF >> take);
        merged    = buf_reg | (top_bits >> cnt_reg);
        fill      = {1'b0, cnt_reg} + take;
        full      = (fill == FILL_W'(htebp_pkg::BYTE_W));
        rem_after = rem_reg - htebp_pkg::LEN_W'(take);
        zero_rem  = (rem_reg == '0);
        done      = zero_rem || ((rem_after == '0) && (!end_reg || full));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            htebp_pkg::PK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = htebp_pkg::PK_RUN;
                end
            end
            htebp_pkg::PK_RUN:
            begin
                if (out_free && done)
                begin
                    state_next = htebp_pkg::PK_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        end_next  = end_reg;
        emit      = 1'b0;
        emit_byte = merged;
        emit_last = 1'b0;
        emit_end  = 1'b0;
        unique case (state_reg)
            htebp_pkg::PK_IDLE:
            begin
                pop = !q_status.empty;
                if (!q_status.empty)
                begin
                    // left-align the code so its first bit sits at the top
                    val_next = head.value
                             << (htebp_pkg::LEN_W'(htebp_pkg::VALUE_W) - head.length);
                    rem_next = head.length;
                    end_next = head.is_end;
                end
            end
            htebp_pkg::PK_RUN:
            begin
                if (out_free)
                begin
                    if (zero_rem)
                    begin
                        // end of stream: flush the partial byte, zero padded
                        if (end_reg)
                        begin
                            emit      = 1'b1;
                            emit_byte = buf_reg;
                            emit_last = 1'b1;
                            emit_end  = 1'b1;
                            buf_next  = '0;
                            cnt_next  = '0;
                        end
                    end
                    else
                    begin
                        val_next = val_reg << take;
                        rem_next = rem_after;
                        if (full)
                        begin
                            emit      = 1'b1;
                            emit_end  = end_reg && (rem_after == '0);
                            emit_last = end_reg ? (rem_after == '0)
                                      : (rem_after < htebp_pkg::LEN_W'(htebp_pkg::BYTE_W));
                            buf_next  = '0;
                            cnt_next  = '0;
                        end
                        else
                        begin
                            buf_next = merged;
                            cnt_next = fill[htebp_pkg::CNT_W-1:0];
                        end
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
            out_end_next   = emit_end;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htebp_pkg::PK_IDLE;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.last_of_run = out_last_reg;
    assign out_ch.stream_end  = out_end_reg;

endmodule

/* src/huffman_table_encoder_bit_packer.sv */
// top level of the table-driven huffman encoder with msb-first byte packer
//
//   channel   dir   words                                   handshake
//   in_ch     in    action, symbol, code_value, code_length valid/ready
//   out_ch    out   out_byte, last_of_run, stream_end       valid/ready
//   apb       in    eof_symbol at byte address 0            psel/penable, pready high
//
// a load is written to the table in the front end; an encode or end word is looked up in
// the table (one registered read) and queued for the packer
// the packer picks up a command in its idle state, then emits one output byte per cycle
// while out_ch is free, plus a step for code bits left in a partial byte (a zero-length
// code still takes one step)
// out_ch stalls hold the packer; the queue lets the front end keep taking words
// reset clears the packer and queue and sets eof_symbol to 129; the code table is not cleared
module huffman_table_encoder_bit_packer (
    input  logic                               clk,
    input  logic                               rst_n,
    htebp_in_if.sink                           in_ch,
    htebp_out_if.source                        out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [htebp_pkg::PADDR_W-1:0]      paddr,
    input  logic [htebp_pkg::PDATA_W-1:0]      pwdata,
    output logic [htebp_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    logic [htebp_pkg::BYTE_W-1:0] eof_symbol_reg, eof_symbol_next;
    htebp_pkg::reg_index_t        reg_sel;
    htebp_pkg::q_status_t         q_status;
    htebp_pkg::cmd_t              push_cmd, head;
    logic                         push, pop;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_sel = htebp_pkg::reg_index_t'(paddr[htebp_pkg::PADDR_W-1]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        eof_symbol_next = eof_symbol_reg;
        if (wr_en && (reg_sel == htebp_pkg::REG_EOF_SYMBOL))
        begin
            eof_symbol_next = pwdata[htebp_pkg::BYTE_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            htebp_pkg::REG_EOF_SYMBOL:
                prdata = {{(htebp_pkg::PDATA_W-htebp_pkg::BYTE_W){1'b0}}, eof_symbol_reg};
            htebp_pkg::REG_UNUSED:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eof_symbol_reg <= htebp_pkg::EOF_RESET;
        end
        else
        begin
            eof_symbol_reg <= eof_symbol_next;
        end
    end

    htebp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .eof_symbol (eof_symbol_reg),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    htebp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    htebp_packer u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

/* src/htebp_checker.sv */
// port-level checks for the huffman encoder, bound to the top level
module htebp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [7:0]                    out_byte,
    input logic                          last_of_run,
    input logic                          stream_end,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [htebp_pkg::PADDR_W-1:0] paddr,
    input logic [htebp_pkg::PDATA_W-1:0] pwdata,
    input logic [htebp_pkg::PDATA_W-1:0] prdata,
    input logic                          pready
);

    // the final byte of a stream is always the last byte of its word
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> last_of_run)
        else $error("stream_end without last_of_run");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(stream_end))
        else $error("stalled output byte changed");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[htebp_pkg::PADDR_W-1]
        |=> paddr[htebp_pkg::PADDR_W-1] || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("eof_symbol readback mismatch");

endmodule

bind huffman_table_encoder_bit_packer htebp_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run),
    .stream_end  (out_ch.stream_end),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

/* sim/huffman_table_encoder_bit_packer_tb.sv */
// self-checking testbench for the huffman table encoder and byte packer
module huffman_table_encoder_bit_packer_tb;
    import htebp_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              fin;
    } coded_byte_t;

    class byte_scoreboard;
        logic [VALUE_W-1:0] code_val [TABLE_DEPTH];
        logic [LEN_W-1:0]   code_len [TABLE_DEPTH];
        logic [BYTE_W-1:0]  pack_buf;
        int                 pack_cnt;
        logic [BYTE_W-1:0]  eof_sym;
        coded_byte_t        run [6];
        int                 run_n;
        coded_byte_t        pending [$];
        int                 errors;

        function new();
            foreach (code_len[i])
            begin
                code_val[i] = '0;
                code_len[i] = '0;
            end
            pack_buf = '0;
            pack_cnt = 0;
            eof_sym  = EOF_RESET;
            errors   = 0;
        endfunction

        // msb-first shift of one table entry into the packer
        function void shift_code(input logic [BYTE_W-1:0] idx);
            for (int b = int'(code_len[idx]); b > 0; b--)
            begin
                if (code_val[idx][b-1])
                    pack_buf[7-pack_cnt] = 1'b1;
                pack_cnt++;
                if (pack_cnt == BYTE_W)
                begin
                    run[run_n] = '{pack_buf, 1'b0, 1'b0};
                    run_n++;
                    pack_buf = '0;
                    pack_cnt = 0;
                end
            end
        endfunction

        function void note_word(input action_t act, input logic [7:0] sym,
                                input logic [31:0] val, input logic [5:0] len);
            run_n = 0;
            case (act)
                ACT_LOAD:
                begin
                    code_val[sym] = val;
                    code_len[sym] = (len > CODE_LIMIT) ? LEN_W'(CODE_LIMIT) : len;
                end
                ACT_ENCODE:
                    shift_code(sym);
                ACT_END:
                begin
                    shift_code(eof_sym);
                    // flush a partial byte, or send a lone zero byte if nothing came out
                    if (pack_cnt != 0 || run_n == 0)
                    begin
                        run[run_n] = '{pack_buf, 1'b0, 1'b1};
                        run_n++;
                    end
                    else
                        run[run_n-1].fin = 1'b1;
                    pack_buf = '0;
                    pack_cnt = 0;
                end
                default: ;
            endcase
            if (run_n > 0)
                run[run_n-1].last = 1'b1;
            for (int i = 0; i < run_n; i++)
                pending.push_back(run[i]);
        endfunction

        function void check_byte(input logic [7:0] data, input logic last, input logic fin);
            coded_byte_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected byte: data=%02h last=%b end=%b", data, last, fin);
                return;
            end
            want = pending.pop_front();
            if (data !== want.data || last !== want.last || fin !== want.fin)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("byte mismatch: expected data=%02h last=%b end=%b, got data=%02h last=%b end=%b",
                             want.data, want.last, want.fin, data, last, fin);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    htebp_in_if  in_ch ();
    htebp_out_if out_ch ();

    byte_scoreboard      sb;
    int                  in_idle_pct;
    int                  out_stall_pct;
    int                  quiet_cycles;
    bit                  loaded [TABLE_DEPTH];
    logic [7:0]          loaded_syms [$];

    huffman_table_encoder_bit_packer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output side: random back-pressure and result checking
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_byte(out_ch.out_byte, out_ch.last_of_run, out_ch.stream_end);
        out_ch.ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input action_t act, input logic [7:0] sym,
                             input logic [31:0] val, input logic [5:0] len);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.symbol      <= sym;
        in_ch.code_value  <= val;
        in_ch.code_length <= len;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_word(act, sym, val, len);
    endtask

    task automatic load_entry(input logic [7:0] sym, input logic [31:0] val,
                              input logic [5:0] len);
        send_word(ACT_LOAD, sym, val, len);
        if (!loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // hold the input side until every byte has drained, then optionally settle
    task automatic wait_for_results(input bit settle);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_eof(input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_EOF_SYMBOL, 2'b00};
        pwdata  <= ($urandom & 32'hFFFF_FF00) | {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.eof_sym = val;
    endtask

    function automatic logic [5:0] random_length();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 6'd0;
        if (r < 80)
            return 6'($urandom_range(12, 1));
        if (r < 93)
            return 6'($urandom_range(32, 13));
        return 6'($urandom_range(63, 33));
    endfunction

    task automatic run_phase(input logic [7:0] eof_val, input int idle_pct,
                             input int stall_pct, input int n_words, input int pause_at);
        int done;
        int pick;
        done = 0;
        wait_for_results(1'b1);
        write_eof(eof_val);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        load_entry(eof_val, 32'($urandom), random_length());
        while (done < n_words)
        begin
            if (done == pause_at)
                wait_for_results(1'b0);
            pick = $urandom_range(99);
            if (pick < 4)
                send_word(ACT_NONE, 8'($urandom), 32'($urandom), 6'($urandom));
            else
            begin
                if (pick < 22)
                    load_entry(8'($urandom), 32'($urandom), random_length());
                else if (pick < 88)
                    send_word(ACT_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                              32'($urandom), 6'($urandom));
                else
                    send_word(ACT_END, 8'($urandom), 32'($urandom), 6'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        sb                = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_NONE;
        in_ch.symbol      = '0;
        in_ch.code_value  = '0;
        in_ch.code_length = '0;
        out_ch.ready      = 1'b0;
        in_idle_pct       = 0;
        out_stall_pct     = 0;
        quiet_cycles      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words with eof_symbol still at its reset value
        load_entry(8'd0, 32'hFFFF_FFFF, 6'd32);
        load_entry(8'd255, 32'h0000_0000, 6'd1);
        load_entry(8'd129, 32'h0000_0005, 6'd3);
        load_entry(8'd10, 32'hAAAA_AAAA, 6'd63);      // saturates to the full code width
        load_entry(8'd11, 32'h1234_5678, 6'd0);       // zero-length code
        load_entry(8'd12, 32'h8000_0001, 6'd33);
        send_word(ACT_NONE, 8'($urandom), 32'($urandom), 6'($urandom));
        send_word(ACT_ENCODE, 8'd255, 32'd0, 6'd0);
        send_word(ACT_ENCODE, 8'd0, 32'd0, 6'd0);
        send_word(ACT_ENCODE, 8'd11, 32'd0, 6'd0);
        send_word(ACT_ENCODE, 8'd10, 32'd0, 6'd0);
        send_word(ACT_ENCODE, 8'd12, 32'd0, 6'd0);
        send_word(ACT_END, 8'd0, 32'd0, 6'd0);
        send_word(ACT_END, 8'd0, 32'd0, 6'd0);        // empty packer, partial flush
        load_entry(8'd129, 32'h0000_00C3, 6'd8);
        send_word(ACT_END, 8'd0, 32'd0, 6'd0);        // end code fills exactly one byte
        send_word(ACT_ENCODE, 8'd255, 32'd0, 6'd0);
        load_entry(8'd129, 32'h0000_007F, 6'd7);
        send_word(ACT_END, 8'd0, 32'd0, 6'd0);        // end code tops up a partial byte
        load_entry(8'd129, 32'hFFFF_FFFF, 6'd0);
        send_word(ACT_END, 8'd0, 32'd0, 6'd0);        // no bits at all: lone zero byte
        send_word(ACT_ENCODE, 8'd255, 32'd0, 6'd0);
        send_word(ACT_END, 8'd0, 32'd0, 6'd0);
        load_entry(8'd129, 32'h0000_0005, 6'd3);

        run_phase(8'd0, 0, 0, 72, -1);
        run_phase(8'd255, 78, 0, 72, -1);
        run_phase(8'($urandom), 0, 78, 72, 30);
        run_phase(EOF_RESET, 38, 38, 72, -1);

        wait_for_results(1'b1);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
